>>> sv/dll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dll_pkg;
	typedef enum logic [2:0] {
		FN_INS_FRONT = 3'd0,
		FN_INS_BACK  = 3'd1,
		FN_INS_POS   = 3'd2,
		FN_DEL_FRONT = 3'd3,
		FN_DEL_BACK  = 3'd4,
		FN_DEL_POS   = 3'd5,
		FN_TRAVERSE  = 3'd6,
		FN_NONE      = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_WALK,
		S_WALK_WAIT,
		S_LINK,
		S_DEL_RD,
		S_DEL_WAIT,
		S_UNLINK,
		S_TRAV_RD,
		S_TRAV_WAIT,
		S_TRAV_OUT
	} state_t;
endpackage
`default_nettype wire

>>> sv/dll_free_map.sv
`timescale 1ns / 1ps
`default_nettype none
module dll_free_map #(
	parameter int POOL_DEPTH = 64,
	parameter int SW = $clog2(POOL_DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          set_en,
	input  wire logic          clr_en,
	input  wire logic [SW-1:0] slot,
	output logic      [SW-1:0] free_slot,
	output logic               full
);
	localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	logic [POOL_DEPTH-1:0] used_q;
	logic [SW-1:0] scan_q;
	logic [POOL_DEPTH-1:0] nxt;

	always_comb begin
		nxt = used_q;
		if (set_en)
			nxt[slot[IW-1:0]] = 1'b1;
		if (clr_en)
			nxt[slot[IW-1:0]] = 1'b0;
	end

	// lowest free slot kept registered; it advances one slot a cycle while the slot it holds is used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			scan_q <= '0;
		end else begin
			used_q <= nxt;
			if (clr_en && slot < scan_q)
				scan_q <= slot;
			else if (scan_q < SW'(POOL_DEPTH) && nxt[scan_q[IW-1:0]])
				scan_q <= scan_q + 1'b1;
		end
	end

	assign free_slot = scan_q;
	assign full = (scan_q == SW'(POOL_DEPTH)) || used_q[scan_q[IW-1:0]];
endmodule
`default_nettype wire

>>> sv/doubly_linked_list_manager.sv
`timescale 1ns / 1ps
`default_nettype none
// Rejected or unused commands answer from idle; insert front/back runs FIND, LINK; delete
// front/back runs DEL_RD, DEL_WAIT, UNLINK. Insert above position 2 or delete above 1 first
// walks the list, WALK then WALK_WAIT per node. Traverse strobes each item from TRAV_OUT
// after TRAV_RD and TRAV_WAIT. One item at a time; busy holds through the command and,
// after an insert, while the free-slot scan moves past used slots. Results strobe on done.
// Reset clears the list, head, tail, count and free map; node memory is not cleared.
module doubly_linked_list_manager #(
	parameter int POOL_DEPTH = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  func,
	input  wire logic signed [31:0] value,
	input  wire logic [6:0]  position,
	output logic             done,
	output logic [1:0]       status,
	output logic signed [31:0] element,
	output logic [6:0]       length,
	output logic             last
);
	import dll_pkg::*;
	localparam int SW = $clog2(POOL_DEPTH + 1);
	localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam logic [SW-1:0] NIL = SW'(POOL_DEPTH);

	logic [DATA_WIDTH-1:0] val_mem [POOL_DEPTH];
	logic [SW-1:0] nxt_mem [POOL_DEPTH];
	logic [SW-1:0] prv_mem [POOL_DEPTH];

	state_t state_q, state_d;
	logic [SW-1:0] head_q, tail_q, cnt_q;
	logic [SW-1:0] cur_q, slot_q;
	logic [6:0] k_q;
	logic [2:0] func_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [6:0] pos_q;

	logic rd_en;
	logic [SW-1:0] rd_addr;
	logic [DATA_WIDTH-1:0] rd_val;
	logic [SW-1:0] rd_nxt, rd_prv;

	logic [SW-1:0] free_slot;
	logic full, set_en, clr_en;

	dll_free_map #(.POOL_DEPTH(POOL_DEPTH), .SW(SW)) u_map (
		.clk(clk), .arst_n(arst_n), .set_en(set_en), .clr_en(clr_en),
		.slot(slot_q), .free_slot(free_slot), .full(full));

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_val <= val_mem[rd_addr[IW-1:0]];
			rd_nxt <= nxt_mem[rd_addr[IW-1:0]];
			rd_prv <= prv_mem[rd_addr[IW-1:0]];
		end
	end

	// insert: new node + fix neighbors; delete: fix neighbors
	logic link_go, unl_go;
	logic [SW-1:0] aft;
	assign aft = (cur_q == NIL) ? head_q : rd_nxt;
	always_ff @(posedge clk) begin
		if (link_go) begin
			val_mem[slot_q[IW-1:0]] <= val_q;
			prv_mem[slot_q[IW-1:0]] <= cur_q;
			nxt_mem[slot_q[IW-1:0]] <= aft;
			if (cur_q != NIL)
				nxt_mem[cur_q[IW-1:0]] <= slot_q;
			if (aft != NIL)
				prv_mem[aft[IW-1:0]] <= slot_q;
		end else if (unl_go) begin
			if (rd_prv != NIL)
				nxt_mem[rd_prv[IW-1:0]] <= rd_nxt;
			if (rd_nxt != NIL)
				prv_mem[rd_nxt[IW-1:0]] <= rd_prv;
		end
	end

	assign set_en = link_go;
	assign clr_en = unl_go;

	logic [SW-1:0] head_d, tail_d, cnt_d, cur_d, slot_d;
	logic [6:0] k_d;
	logic out_v;
	logic [1:0] out_st;
	logic [31:0] out_el;
	logic out_last;

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		tail_d = tail_q;
		cnt_d = cnt_q;
		cur_d = cur_q;
		slot_d = slot_q;
		k_d = k_q;
		rd_en = 1'b0;
		rd_addr = cur_q;
		link_go = 1'b0;
		unl_go = 1'b0;
		out_v = 1'b0;
		out_st = ST_OK;
		out_el = '0;
		out_last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (start && !busy) begin
					k_d = 7'd1;
					case (func_t'(func))
						FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
							if (func == FN_INS_POS && (position == 7'd0 ||
								32'(position) > 32'(cnt_q) + 1)) begin
								out_v = 1'b1;
								out_st = ST_RANGE;
							end else if (full) begin
								out_v = 1'b1;
								out_st = ST_FULL;
							end else begin
								slot_d = free_slot;
								cur_d = (func == FN_INS_BACK) ? tail_q : NIL;
								if (func == FN_INS_POS && position > 7'd1) begin
									cur_d = head_q;
									state_d = (position > 7'd2) ? S_WALK : S_FIND;
								end else begin
									state_d = S_FIND;
								end
							end
						end
						FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_POS: begin
							if (cnt_q == '0) begin
								out_v = 1'b1;
								out_st = ST_EMPTY;
							end else if (func == FN_DEL_POS && (position == 7'd0 ||
								32'(position) > 32'(cnt_q))) begin
								out_v = 1'b1;
								out_st = ST_RANGE;
							end else begin
								cur_d = (func == FN_DEL_BACK) ? tail_q : head_q;
								state_d = (func == FN_DEL_POS && position > 7'd1) ?
									S_WALK : S_DEL_RD;
							end
						end
						FN_TRAVERSE: begin
							if (cnt_q == '0) begin
								out_v = 1'b1;
								out_st = ST_EMPTY;
							end else begin
								cur_d = head_q;
								state_d = S_TRAV_RD;
							end
						end
						default: out_v = 1'b1;
					endcase
				end
			end
			S_WALK: begin
				rd_en = 1'b1;
				state_d = S_WALK_WAIT;
			end
			S_WALK_WAIT: begin
				cur_d = rd_nxt;
				k_d = k_q + 7'd1;
				// insert stops at pos-1, delete at pos
				if ((func_q == FN_INS_POS && k_q + 7'd1 == pos_q - 7'd1) ||
					(func_q == FN_DEL_POS && k_q + 7'd1 == pos_q))
					state_d = (func_q == FN_INS_POS) ? S_FIND : S_DEL_RD;
				else
					state_d = S_WALK;
			end
			S_FIND: begin
				rd_en = 1'b1;
				state_d = S_LINK;
			end
			S_LINK: begin
				link_go = 1'b1;
				if (cur_q == NIL)
					head_d = slot_q;
				if (aft == NIL)
					tail_d = slot_q;
				cnt_d = cnt_q + 1'b1;
				out_v = 1'b1;
				state_d = S_IDLE;
			end
			S_DEL_RD: begin
				rd_en = 1'b1;
				slot_d = cur_q;
				state_d = S_DEL_WAIT;
			end
			S_DEL_WAIT: state_d = S_UNLINK;
			S_UNLINK: begin
				unl_go = 1'b1;
				if (rd_prv == NIL)
					head_d = rd_nxt;
				if (rd_nxt == NIL)
					tail_d = rd_prv;
				cnt_d = cnt_q - 1'b1;
				out_v = 1'b1;
				state_d = S_IDLE;
			end
			S_TRAV_RD: begin
				rd_en = 1'b1;
				state_d = S_TRAV_WAIT;
			end
			S_TRAV_WAIT: state_d = S_TRAV_OUT;
			S_TRAV_OUT: begin
				out_v = 1'b1;
				out_el = 32'($signed(rd_val));
				out_last = (rd_nxt == NIL) || (32'(k_q) >= POOL_DEPTH);
				cur_d = rd_nxt;
				k_d = k_q + 7'd1;
				state_d = out_last ? S_IDLE : S_TRAV_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// hold busy while a command runs or the free scan still sits on a used slot
	assign busy = (state_q != S_IDLE) || (full && free_slot != NIL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= NIL;
			tail_q <= NIL;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q <= cnt_d;
			done <= out_v;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		slot_q <= slot_d;
		k_q <= k_d;
		if (start && !busy) begin
			func_q <= func;
			val_q <= DATA_WIDTH'(value);
			pos_q <= position;
		end
		status <= out_st;
		element <= out_el;
		length <= 7'(cnt_d);
		last <= out_last;
	end

	ap_len: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NIL) else $error("count overflow");
	ap_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (head_q == NIL && tail_q == NIL)) else $error("empty list links");
	ap_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !(done && state_q != S_IDLE && last)) else $error("last early");
endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import dll_pkg::*;

	localparam int DEPTH = 64;
	localparam int NIL = DEPTH;
	localparam int WATCH_LIMIT = 20000;

	typedef struct {
		status_t     st;
		logic [31:0] elem;
		logic [6:0]  len;
		logic        fin;
	} list_result_t;

	class list_scoreboard;
		logic [31:0] vals[DEPTH];
		int          nxt[DEPTH];
		int          prv[DEPTH];
		bit          used[DEPTH];
		int          head, tail, count;
		list_result_t pending[$];
		int          errors;

		function new();
			head = NIL;
			tail = NIL;
			count = 0;
			errors = 0;
		endfunction

		function void push(status_t st, logic [31:0] e, logic f);
			list_result_t r;
			r.st = st;
			r.elem = e;
			r.len = count[6:0];
			r.fin = f;
			pending.push_back(r);
		endfunction

		function int slot_at(int k);
			int s;
			s = head;
			for (int i = 1; i < k && s < NIL; i++) s = nxt[s];
			return s;
		endfunction

		function void link_after(int b, int s, logic [31:0] v);
			int a;
			a = (b < NIL) ? nxt[b] : head;
			vals[s] = v;
			prv[s] = b;
			nxt[s] = a;
			if (b < NIL) nxt[b] = s; else head = s;
			if (a < NIL) prv[a] = s; else tail = s;
			used[s] = 1;
			count++;
		endfunction

		function void unlink(int s);
			int p, n;
			p = prv[s];
			n = nxt[s];
			if (p < NIL) nxt[p] = n; else head = n;
			if (n < NIL) prv[n] = p; else tail = p;
			used[s] = 0;
			count--;
		endfunction

		function void note_command(func_t f, logic [31:0] v, int pos);
			int s, k;
			case (f)
				FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
					if (f == FN_INS_POS && (pos < 1 || pos > count + 1)) begin
						push(ST_RANGE, 0, 1);
						return;
					end
					s = NIL;
					for (int i = DEPTH - 1; i >= 0; i--) if (!used[i]) s = i;
					if (s == NIL) begin
						push(ST_FULL, 0, 1);
						return;
					end
					if (f == FN_INS_FRONT) link_after(NIL, s, v);
					else if (f == FN_INS_BACK) link_after(tail, s, v);
					else link_after(pos == 1 ? NIL : slot_at(pos - 1), s, v);
					push(ST_OK, 0, 1);
				end
				FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_POS: begin
					if (count == 0) begin
						push(ST_EMPTY, 0, 1);
						return;
					end
					if (f == FN_DEL_POS && (pos < 1 || pos > count)) begin
						push(ST_RANGE, 0, 1);
						return;
					end
					if (f == FN_DEL_FRONT) unlink(head);
					else if (f == FN_DEL_BACK) unlink(tail);
					else unlink(slot_at(pos));
					push(ST_OK, 0, 1);
				end
				FN_TRAVERSE: begin
					if (count == 0) begin
						push(ST_EMPTY, 0, 1);
						return;
					end
					s = head;
					k = 0;
					while (s < NIL && k < DEPTH) begin
						push(ST_OK, vals[s], nxt[s] >= NIL || k + 1 >= DEPTH);
						s = nxt[s];
						k++;
					end
				end
				default: push(ST_OK, 0, 1);
			endcase
		endfunction

		function void check_result(logic [1:0] st, logic [31:0] e, logic [6:0] len, logic f);
			list_result_t x;
			if (pending.size() == 0) begin
				$error("result with none expected: status=%0d element=%0d", st, $signed(e));
				errors++;
				return;
			end
			x = pending.pop_front();
			if (st !== x.st) begin
				$error("status: expected %0d actual %0d", x.st, st);
				errors++;
			end
			if (e !== x.elem) begin
				$error("element: expected %0d actual %0d", $signed(x.elem), $signed(e));
				errors++;
			end
			if (len !== x.len) begin
				$error("length: expected %0d actual %0d", x.len, len);
				errors++;
			end
			if (f !== x.fin) begin
				$error("last: expected %0d actual %0d", x.fin, f);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [2:0] func = 0;
	logic signed [31:0] value = 0;
	logic [6:0] position = 0;
	logic busy, done, last;
	logic [1:0] status;
	logic signed [31:0] element;
	logic [6:0] length;

	list_scoreboard sb = new();
	int idle_pct = 0;
	int quiet = 0;
	int n_cmds = 0;
	int n_results = 0;

	always #5 clk = ~clk;

	doubly_linked_list_manager dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.value(value), .position(position), .done(done), .status(status),
		.element(element), .length(length), .last(last)
	);

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(status, element, length, last);
			n_results++;
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > WATCH_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send(func_t f, logic [31:0] v, int pos);
		if ($urandom_range(99, 0) < idle_pct) begin
			start <= 0;
			@(posedge clk);
			while ($urandom_range(99, 0) < idle_pct) @(posedge clk);
		end
		start <= 1;
		func <= f;
		value <= v;
		position <= pos[6:0];
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_command(f, v, pos);
		n_cmds++;
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_value();
		case ($urandom_range(3, 0))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_cmd();
		int r, c;
		func_t f;
		c = sb.count;
		r = $urandom_range(99, 0);
		if (r < 20) f = FN_INS_FRONT;
		else if (r < 40) f = FN_INS_BACK;
		else if (r < 58) f = FN_INS_POS;
		else if (r < 66) f = FN_DEL_FRONT;
		else if (r < 74) f = FN_DEL_BACK;
		else if (r < 86) f = FN_DEL_POS;
		else if (r < 98) f = FN_TRAVERSE;
		else f = FN_NONE;
		if ($urandom_range(9, 0) == 0) send(f, rnd_value(), $urandom_range(127, 0));
		else send(f, rnd_value(), $urandom_range(c + 1, 0));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(FN_TRAVERSE, 0, 0);
		send(FN_DEL_FRONT, 0, 0);
		send(FN_DEL_BACK, 0, 0);
		send(FN_DEL_POS, 0, 1);
		send(FN_INS_POS, 32'h1, 0);
		send(FN_INS_POS, 32'h2, 2);
		send(FN_INS_POS, 32'h8000_0000, 1);
		send(FN_INS_FRONT, 32'h7fff_ffff, 0);
		send(FN_INS_BACK, 32'hffff_ffff, 0);
		send(FN_INS_POS, 32'h0, 4);
		send(FN_INS_POS, 32'h5a5a_a5a5, 127);
		send(FN_TRAVERSE, 0, 0);
		send(FN_DEL_POS, 0, 0);
		send(FN_DEL_POS, 0, 5);
		send(FN_DEL_POS, 0, 2);
		send(FN_DEL_FRONT, 0, 0);
		send(FN_DEL_BACK, 0, 0);
		send(FN_NONE, 32'h1234, 3);
		send(FN_TRAVERSE, 0, 0);
		drain();
		// fill the pool, overflow it, then free slots in the middle
		while (sb.count < DEPTH) send(FN_INS_BACK, $urandom, 0);
		send(FN_INS_FRONT, 32'h3, 0);
		send(FN_INS_POS, 32'h3, 65);
		send(FN_INS_POS, 32'h3, 66);
		send(FN_TRAVERSE, 0, 0);
		send(FN_DEL_POS, 0, 64);
		send(FN_DEL_POS, 0, 30);
		send(FN_INS_POS, 32'hdead_beef, 64);
		send(FN_DEL_POS, 0, 65);
		drain();
		while (sb.count > 40) send(FN_DEL_POS, 0, $urandom_range(sb.count, 1));
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 1) ? 76 : (ph == 2) ? 7 : 30;
			for (int i = 0; i < 17; i++) random_cmd();
			drain();
		end
		repeat (200) @(posedge clk);
		$display("Ran %0d commands with %0d results, including full-pool, empty and",
			n_cmds, n_results);
		$display("out-of-range cases and traversals of long lists.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
